FILE: rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg: shared types, constants and functions of the line clip unit
// Outcode bits, register indexes, sequencer states and saturation helpers.
// ----------------------------------------------------------------------------
package lcr_pkg;

	// Fractional bits of the Q16.16 format.
	localparam int unsigned QFRAC = 16;

	// Outcode bits; y grows downward, so "below" means y beyond the bottom edge.
	localparam logic [3:0] CODE_LEFT  = 4'd1;
	localparam logic [3:0] CODE_RIGHT = 4'd2;
	localparam logic [3:0] CODE_BELOW = 4'd4;
	localparam logic [3:0] CODE_ABOVE = 4'd8;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_TOP    = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	// Clip stages run per segment before it is accepted as it stands.
	localparam logic [2:0] MAX_STAGES = 3'd4;

	// Divider: 33-bit difference scaled by 2^16 gives a 49-bit dividend.
	localparam int unsigned DIV_NUM_W = 33;
	localparam int unsigned DIV_DVD_W = DIV_NUM_W + QFRAC;
	localparam logic [5:0]  DIV_STEPS = 6'(DIV_DVD_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_A,
		ST_WAIT_A,
		ST_DIV_B,
		ST_WAIT_B,
		ST_STAGE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// Outcode of one point against the rectangle; points on an edge are inside.
	function automatic logic [3:0] outcode(
		input logic signed [31:0] x,
		input logic signed [31:0] y,
		input logic signed [31:0] left,
		input logic signed [31:0] right,
		input logic signed [31:0] top,
		input logic signed [31:0] bottom
	);
		logic [3:0] c;
		c = '0;
		if (x < left) begin
			c = c | CODE_LEFT;
		end else if (x > right) begin
			c = c | CODE_RIGHT;
		end
		if (y > bottom) begin
			c = c | CODE_BELOW;
		end else if (y < top) begin
			c = c | CODE_ABOVE;
		end
		return c;
	endfunction

	// Saturate a 50-bit signed sum to 32 bits.
	function automatic logic [31:0] sat50(input logic [49:0] v);
		logic [31:0] r;
		if (v[49:31] == {19{v[49]}}) begin
			r = v[31:0];
		end else if (v[49]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

FILE: rtl/line_clip_to_rectangle_unit.sv
// ----------------------------------------------------------------------------
// line_clip_to_rectangle_unit: Cohen-Sutherland clipping of one segment
// Sequence: the divider forms the two slopes in turn (49 quotient bits each), then
//   each stage makes one decision, each clip runs MUL_LO, MUL_HI, ROUND and ADD,
//   and the finished segment moves to the output register.
// Flow: one segment at a time; the bit-serial divider and the two-pass 32x17
//   multiplier set the pace. The input is not ready meanwhile.
// Reset: arst_n clears the sequencer, the stage count, the output valid and the clip rectangle to 0.
// ----------------------------------------------------------------------------
module line_clip_to_rectangle_unit (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // first_x, first_y, second_x, second_y
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // out_first_x, out_first_y, out_second_x, out_second_y
	output logic [0:0]   m_tuser,  // accepted
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	lcr_pkg::state_t state_q, state_d;

	// Clip rectangle; the user must write it over the configuration port while idle (not enforced).
	logic signed [31:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;

	// Working endpoints: p is the point being clipped, q the other one.
	logic signed [31:0] px_q, py_q, qx_q, qy_q;
	logic signed [31:0] dydx_q, dxdy_q;
	logic [2:0]         stage_q;
	logic               acc_q;

	// Operands of the current clip step.
	logic signed [31:0] slope_q;
	logic signed [32:0] d_q;
	logic signed [31:0] coord_q;
	logic               xclip_q;
	logic signed [64:0] prod_q;
	logic signed [48:0] q_q;

	// Output register.
	logic               m_tvalid_q;
	logic [127:0]       out_data_q;
	logic               out_acc_q;

	// Divider hookup.
	logic                div_start;
	logic signed [32:0]  div_num, div_den;
	logic                div_done;
	logic signed [31:0]  div_quot;

	// Stage decision.
	logic [3:0]         cs, ce, code;
	logic               resolved, accept_now, swap;
	logic signed [31:0] pcx, pcy, edge_val;
	logic               x_clip;
	logic signed [32:0] d_new;

	// Shared multiplier.
	logic signed [16:0] mul_b;
	logic signed [48:0] product;
	logic [49:0]        sum;

	logic cfg_wr, in_acc, out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign in_acc = s_tvalid & s_tready;

	// Register writes and reads; the low address bits are not decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_right_q  <= '0;
			clip_top_q    <= '0;
			clip_bottom_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lcr_pkg::REG_LEFT:   clip_left_q   <= pwdata;
				lcr_pkg::REG_RIGHT:  clip_right_q  <= pwdata;
				lcr_pkg::REG_TOP:    clip_top_q    <= pwdata;
				lcr_pkg::REG_BOTTOM: clip_bottom_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lcr_pkg::REG_LEFT:   prdata = clip_left_q;
			lcr_pkg::REG_RIGHT:  prdata = clip_right_q;
			lcr_pkg::REG_TOP:    prdata = clip_top_q;
			lcr_pkg::REG_BOTTOM: prdata = clip_bottom_q;
			default:             prdata = '0;
		endcase
	end

	// The divider computes dy/dx first, then dx/dy, both from the input points.
	lcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// The outcodes follow from the points themselves: the code of q only
	// changes on a swap, and then q takes a point that was inside.
	always_comb begin
		cs = lcr_pkg::outcode(px_q, py_q, clip_left_q, clip_right_q, clip_top_q,
			clip_bottom_q);
		ce = lcr_pkg::outcode(qx_q, qy_q, clip_left_q, clip_right_q, clip_top_q,
			clip_bottom_q);
		accept_now = (stage_q == lcr_pkg::MAX_STAGES) || ((cs | ce) == '0);
		resolved   = accept_now || ((cs & ce) != '0);
		swap       = (cs == '0);
		code       = swap ? ce : cs;
		pcx        = swap ? qx_q : px_q;
		pcy        = swap ? qy_q : py_q;
		priority if ((code & lcr_pkg::CODE_LEFT) != '0) begin
			x_clip   = 1'b1;
			edge_val = clip_left_q;
		end else if ((code & lcr_pkg::CODE_RIGHT) != '0) begin
			x_clip   = 1'b1;
			edge_val = clip_right_q;
		end else if ((code & lcr_pkg::CODE_BELOW) != '0) begin
			x_clip   = 1'b0;
			edge_val = clip_bottom_q;
		end else begin
			x_clip   = 1'b0;
			edge_val = clip_top_q;
		end
		// Distance from the point to the chosen edge, exact at 33 bits.
		d_new = {edge_val[31], edge_val} - (x_clip ? {pcx[31], pcx} : {pcy[31], pcy});
	end

	// The one multiplier takes the low then the high half of the distance.
	always_comb begin
		mul_b   = (state_q == lcr_pkg::ST_MUL_LO) ? $signed({1'b0, d_q[15:0]}) : d_q[32:16];
		product = slope_q * mul_b;
		sum     = {{18{coord_q[31]}}, coord_q} + {q_q[48], q_q};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcr_pkg::ST_IDLE:   if (s_tvalid) state_d = lcr_pkg::ST_DIV_A;
			lcr_pkg::ST_DIV_A:  state_d = lcr_pkg::ST_WAIT_A;
			lcr_pkg::ST_WAIT_A: if (div_done) state_d = lcr_pkg::ST_DIV_B;
			lcr_pkg::ST_DIV_B:  state_d = lcr_pkg::ST_WAIT_B;
			lcr_pkg::ST_WAIT_B: if (div_done) state_d = lcr_pkg::ST_STAGE;
			lcr_pkg::ST_STAGE:  state_d = resolved ? lcr_pkg::ST_OUT : lcr_pkg::ST_MUL_LO;
			lcr_pkg::ST_MUL_LO: state_d = lcr_pkg::ST_MUL_HI;
			lcr_pkg::ST_MUL_HI: state_d = lcr_pkg::ST_ROUND;
			lcr_pkg::ST_ROUND:  state_d = lcr_pkg::ST_ADD;
			lcr_pkg::ST_ADD:    state_d = lcr_pkg::ST_STAGE;
			lcr_pkg::ST_OUT:    if (out_load) state_d = lcr_pkg::ST_IDLE;
			default:            state_d = lcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == lcr_pkg::ST_IDLE);
		div_start = (state_q == lcr_pkg::ST_DIV_A) || (state_q == lcr_pkg::ST_DIV_B);
		if (state_q == lcr_pkg::ST_DIV_A) begin
			div_num = {qy_q[31], qy_q} - {py_q[31], py_q};
			div_den = {qx_q[31], qx_q} - {px_q[31], px_q};
		end else begin
			div_num = {qx_q[31], qx_q} - {px_q[31], px_q};
			div_den = {qy_q[31], qy_q} - {py_q[31], py_q};
		end
		// A finished result moves out once the output register is free.
		out_load = (state_q == lcr_pkg::ST_OUT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcr_pkg::ST_IDLE;
			stage_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				stage_q <= '0;
			end else if (state_q == lcr_pkg::ST_ADD) begin
				stage_q <= stage_q + 3'd1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= s_tdata[31:0];
			py_q <= s_tdata[63:32];
			qx_q <= s_tdata[95:64];
			qy_q <= s_tdata[127:96];
		end
		if ((state_q == lcr_pkg::ST_WAIT_A) && div_done) begin
			dydx_q <= div_quot;
		end
		if ((state_q == lcr_pkg::ST_WAIT_B) && div_done) begin
			dxdy_q <= div_quot;
		end
		if (state_q == lcr_pkg::ST_STAGE) begin
			acc_q <= accept_now;
			if (!resolved) begin
				// Put the outside point first and pin it to the edge; the
				// other coordinate is advanced along the slope afterwards.
				if (swap) begin
					qx_q <= px_q;
					qy_q <= py_q;
				end
				px_q    <= x_clip ? edge_val : pcx;
				py_q    <= x_clip ? pcy : edge_val;
				coord_q <= x_clip ? pcy : pcx;
				slope_q <= x_clip ? dydx_q : dxdy_q;
				d_q     <= d_new;
				xclip_q <= x_clip;
			end
		end
		if (state_q == lcr_pkg::ST_MUL_LO) begin
			prod_q <= {{16{product[48]}}, product};
		end
		if (state_q == lcr_pkg::ST_MUL_HI) begin
			prod_q <= prod_q + {product, 16'b0};
		end
		if (state_q == lcr_pkg::ST_ROUND) begin
			// Shift by 2^16 with truncation toward zero.
			q_q <= prod_q[64:16] + {48'b0, prod_q[64] & (prod_q[15:0] != '0)};
		end
		if (state_q == lcr_pkg::ST_ADD) begin
			if (xclip_q) begin
				py_q <= lcr_pkg::sat50(sum);
			end else begin
				px_q <= lcr_pkg::sat50(sum);
			end
		end
		if (out_load) begin
			out_data_q <= {qy_q, qx_q, py_q, px_q};
			out_acc_q  <= acc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_acc_q;

endmodule

FILE: rtl/lcr_div.sv
// ----------------------------------------------------------------------------
// lcr_div: bit-serial signed divider for the Q16.16 slopes
// Restoring division on magnitudes, one quotient bit per cycle, with the
// quotient truncated toward zero and saturated to 32 bits; zero divisor gives 0.
// ----------------------------------------------------------------------------
module lcr_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lcr_pkg::DIV_NUM_W-1:0] num,
	input  logic signed [lcr_pkg::DIV_NUM_W-1:0] den,
	output logic                                done,
	output logic signed [31:0]                  quot
);

	localparam int unsigned NW = lcr_pkg::DIV_NUM_W;
	localparam int unsigned DW = lcr_pkg::DIV_DVD_W;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [NW-1:0] den_q;
	logic          neg_q;
	logic          zero_q;

	logic [NW-1:0] num_mag;
	logic [NW-1:0] den_mag;
	logic [NW:0]   trial;
	logic [NW+1:0] diff;
	logic          fits;

	always_comb begin
		num_mag = num[NW-1] ? (~num + 1'b1) : num;
		den_mag = den[NW-1] ? (~den + 1'b1) : den;
		trial   = {rem_q, quo_q[DW-1]};
		diff    = {1'b0, trial} - {2'b00, den_q};
		fits    = ~diff[NW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == lcr_pkg::DIV_STEPS - 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= {num_mag, {lcr_pkg::QFRAC{1'b0}}};
			den_q  <= den_mag;
			neg_q  <= num[NW-1] ^ den[NW-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[NW-1:0];
			end else begin
				rem_q <= trial[NW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	always_comb begin
		if (zero_q) begin
			quot = '0;
		end else if (!neg_q) begin
			quot = (quo_q > DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
		end else begin
			quot = (quo_q > DW'(32'h8000_0000)) ? 32'sh8000_0000 :
				$signed(~quo_q[31:0] + 32'd1);
		end
	end

	assign done = done_q;

endmodule

FILE: bench/line_clip_checker.sv
// ----------------------------------------------------------------------------
// line_clip_checker: result checker for the line clip unit
// Mirrors the clip rectangle from configuration writes and computes the
// expected clip of every segment beat. Each result beat is compared in
// order against the oldest expected clip.
// ----------------------------------------------------------------------------
module line_clip_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,  // first_x, first_y, second_x, second_y
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,  // out_first_x, out_first_y, out_second_x, out_second_y
	input  logic [0:0]   m_tuser,  // accepted
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic        accepted;
		logic [31:0] first_x;
		logic [31:0] first_y;
		logic [31:0] second_x;
		logic [31:0] second_y;
	} clip_result_t;

	longint       clip_left = 0;
	longint       clip_right = 0;
	longint       clip_top = 0;
	longint       clip_bottom = 0;
	clip_result_t expected_clips[$];
	int           errors = 0;
	int           outstanding = 0;
	int           result_count = 0;

	assign fail_count = errors;
	assign pending    = outstanding;

	function automatic longint saturate_q(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [3:0] region_of(input longint x, input longint y);
		logic [3:0] c;
		c = '0;
		if (x < clip_left) begin
			c = c | lcr_pkg::CODE_LEFT;
		end else if (x > clip_right) begin
			c = c | lcr_pkg::CODE_RIGHT;
		end
		if (y > clip_bottom) begin
			c = c | lcr_pkg::CODE_BELOW;
		end else if (y < clip_top) begin
			c = c | lcr_pkg::CODE_ABOVE;
		end
		return c;
	endfunction

	// Q16.16 slope; a zero run gives a flat slope.
	function automatic longint slope_of(input longint num, input longint den);
		if (den == 0) begin
			return 0;
		end
		return saturate_q((num * 64'sd65536) / den);
	endfunction

	function automatic longint move_to_edge(input longint coord, input longint slope,
			input longint edge_pos, input longint other);
		longint prod;
		prod = slope * (edge_pos - other);
		return saturate_q(coord + prod / 64'sd65536);
	endfunction

	function automatic clip_result_t clip_segment(input logic [127:0] seg);
		longint       px, py, qx, qy, dydx, dxdy, t;
		logic [3:0]   cs, ce;
		logic         acc, done;
		int           stage;
		clip_result_t r;
		px   = longint'($signed(seg[31:0]));
		py   = longint'($signed(seg[63:32]));
		qx   = longint'($signed(seg[95:64]));
		qy   = longint'($signed(seg[127:96]));
		dydx = slope_of(qy - py, qx - px);
		dxdy = slope_of(qx - px, qy - py);
		cs   = region_of(px, py);
		ce   = region_of(qx, qy);
		acc  = 1'b1;
		done = 1'b0;
		for (stage = 0; stage < lcr_pkg::MAX_STAGES && !done; stage++) begin
			if ((cs | ce) == 4'd0) begin
				acc  = 1'b1;
				done = 1'b1;
			end else if ((cs & ce) != 4'd0) begin
				acc  = 1'b0;
				done = 1'b1;
			end else begin
				// Keep the outside point first; only its code is tracked afterward.
				if (cs == 4'd0) begin
					cs = ce;
					ce = 4'd0;
					t = px; px = qx; qx = t;
					t = py; py = qy; qy = t;
				end
				if ((cs & lcr_pkg::CODE_LEFT) != 4'd0) begin
					py = move_to_edge(py, dydx, clip_left, px);
					px = clip_left;
				end else if ((cs & lcr_pkg::CODE_RIGHT) != 4'd0) begin
					py = move_to_edge(py, dydx, clip_right, px);
					px = clip_right;
				end else if ((cs & lcr_pkg::CODE_BELOW) != 4'd0) begin
					px = move_to_edge(px, dxdy, clip_bottom, py);
					py = clip_bottom;
				end else if ((cs & lcr_pkg::CODE_ABOVE) != 4'd0) begin
					px = move_to_edge(px, dxdy, clip_top, py);
					py = clip_top;
				end
				cs = region_of(px, py);
			end
		end
		r.accepted = acc;
		r.first_x  = px[31:0];
		r.first_y  = py[31:0];
		r.second_x = qx[31:0];
		r.second_y = qy[31:0];
		return r;
	endfunction

	always @(posedge clk) begin
		clip_result_t got, want;
		if (!arst_n) begin
			clip_left   = 0;
			clip_right  = 0;
			clip_top    = 0;
			clip_bottom = 0;
			expected_clips.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					lcr_pkg::REG_LEFT:   clip_left   = longint'($signed(pwdata));
					lcr_pkg::REG_RIGHT:  clip_right  = longint'($signed(pwdata));
					lcr_pkg::REG_TOP:    clip_top    = longint'($signed(pwdata));
					lcr_pkg::REG_BOTTOM: clip_bottom = longint'($signed(pwdata));
					default: ;
				endcase
			end
			// The result beat is compared before a new segment is queued.
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
					m_tdata[127:96]};
				if (expected_clips.size() == 0) begin
					errors++;
					$display({"%0t: result beat %0d with no segment pending: expected none",
						" actual acc=%0b (%h,%h)-(%h,%h)"}, $time, result_count,
						got.accepted, got.first_x, got.first_y, got.second_x,
						got.second_y);
				end else begin
					want = expected_clips.pop_front();
					if (got !== want) begin
						errors++;
						$display({"%0t: result %0d mismatch: expected acc=%0b (%h,%h)-(%h,%h)",
							" actual acc=%0b (%h,%h)-(%h,%h)"}, $time, result_count,
							want.accepted, want.first_x, want.first_y, want.second_x,
							want.second_y, got.accepted, got.first_x, got.first_y,
							got.second_x, got.second_y);
					end
				end
				result_count++;
			end
			if (s_tvalid && s_tready) begin
				expected_clips.insert(expected_clips.size(), clip_segment(s_tdata));
			end
		end
		outstanding = expected_clips.size();
	end

endmodule

FILE: bench/line_clip_to_rectangle_unit_tb.sv
// ----------------------------------------------------------------------------
// line_clip_to_rectangle_unit_tb: stimulus and verdict for the line clip unit
// Resets the block, programs a series of clip rectangles over the register
// port and streams directed and random segments through it while both the
// segment and the result side stall at random. A checker beside the block
// predicts every clip and reports mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module line_clip_to_rectangle_unit_tb;

	// Cycles to let pass once nothing is pending, above the block's worst latency.
	localparam int          SETTLE_CYCLES  = 140;
	localparam int          RANDOM_BATCHES = 9;
	localparam int          BATCH_ITEMS    = 206;
	localparam logic [31:0] Q_MIN          = 32'h8000_0000;
	localparam logic [31:0] Q_MAX          = 32'h7FFF_FFFF;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	int           fail_count;
	int           pending;

	// Idle odds in percent per cycle for the segment side and the result side.
	int           send_idle = 6;
	int           recv_idle = 79;

	// Current rectangle, kept so that random coordinates can be aimed at it.
	longint       rect_left = 0;
	longint       rect_right = 0;
	longint       rect_top = 0;
	longint       rect_bottom = 0;

	line_clip_to_rectangle_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	line_clip_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is bounded by a fixed time that is several times the slowest
	// legal run, so a hung handshake ends as a failure.
	initial begin
		#16000000;
		$display("line_clip_to_rectangle_unit_tb: FAIL");
		$finish;
	end

	// The result side decides its ready afresh at every falling edge.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	// Whole Q16.16 units; the directed values stay well inside 16 integer bits.
	function automatic logic [31:0] q(input int v);
		return 32'(v * 65536);
	endfunction

	// Picks one coordinate aimed at the span [lo, hi] of the rectangle: on an
	// edge, a few LSBs off it, around the span, a 32-bit limit, 0, -1 or anywhere.
	function automatic logic [31:0] pick_coord(input longint lo, input longint hi);
		longint      a, b, span, v;
		logic [63:0] r;
		logic [31:0] w;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		span = b - a + 1;
		case ($urandom_range(9))
			0: begin
				w = $urandom;
				v = longint'($signed(w));
			end
			1: v = $urandom_range(1) ? a : b;
			2: v = ($urandom_range(1) ? a : b) + longint'($urandom_range(8)) - 4;
			3: begin
				case ($urandom_range(3))
					0: v = -64'sd2147483648;
					1: v = 64'sd2147483647;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: begin
				r = {$urandom, $urandom};
				v = a - span / 2 + longint'(r % (2 * span));
			end
		endcase
		if (v > 64'sd2147483647) begin
			v = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			v = -64'sd2147483648;
		end
		return v[31:0];
	endfunction

	// One register write: a setup phase, then an access phase that completes
	// on the first rising edge with pready high.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_rect(input logic [31:0] l, input logic [31:0] r,
			input logic [31:0] t, input logic [31:0] b);
		reg_write(lcr_pkg::REG_LEFT, l);
		reg_write(lcr_pkg::REG_RIGHT, r);
		reg_write(lcr_pkg::REG_TOP, t);
		reg_write(lcr_pkg::REG_BOTTOM, b);
		rect_left   = longint'($signed(l));
		rect_right  = longint'($signed(r));
		rect_top    = longint'($signed(t));
		rect_bottom = longint'($signed(b));
	endtask

	// Sends one segment beat. The sender may idle first; valid then stays
	// high until the beat is taken at a rising edge.
	task automatic send_segment(input logic [31:0] fx, input logic [31:0] fy,
			input logic [31:0] sx, input logic [31:0] sy);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
		end
		s_tdata  = {sy, sx, fy, fx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Random segment; a share of them have zero width, zero height or both,
	// which exercises the flat-slope handling of a zero divisor.
	task automatic random_segment();
		logic [31:0] fx, fy, sx, sy;
		fx = pick_coord(rect_left, rect_right);
		fy = pick_coord(rect_top, rect_bottom);
		sx = pick_coord(rect_left, rect_right);
		sy = pick_coord(rect_top, rect_bottom);
		case ($urandom_range(19))
			0: begin
				sx = fx;
				sy = fy;
			end
			1: sx = fx;
			2: sy = fy;
			default: ;
		endcase
		send_segment(fx, fy, sx, sy);
	endtask

	// Waits until every expected result beat has come back, then lets the
	// block settle before the registers may change.
	task automatic drain();
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		longint e0, e1, e2, e3;
		logic [31:0] w0, w1, w2, w3;
		int b;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Against the reset rectangle, a point at the origin and two segments.
		send_segment(32'd0, 32'd0, 32'd0, 32'd0);
		send_segment(q(-1), 32'd0, q(1), 32'd0);
		send_segment(q(3), q(-2), q(5), q(7));
		drain();

		// Directed segments against a rectangle of 200 by 100 units.
		set_rect(q(-100), q(100), q(-50), q(50));
		send_segment(q(-10), q(-10), q(10), q(10));      // trivially inside
		send_segment(q(-200), q(0), q(-150), q(10));     // both left
		send_segment(q(0), q(-80), q(10), q(-60));       // both above
		send_segment(q(-200), q(0), q(200), q(0));       // horizontal, zero dy
		send_segment(q(0), q(-200), q(0), q(200));       // vertical, zero dx
		send_segment(q(300), q(300), q(300), q(300));    // point outside
		send_segment(q(5), q(5), q(5), q(5));            // point inside
		send_segment(q(0), q(0), q(300), q(20));         // inside first, so swapped
		send_segment(q(-200), q(-100), q(200), q(100));  // corner to corner
		send_segment(q(-200), q(-20), q(-80), q(-120));  // misses the corner
		send_segment(q(-100), q(-50), q(100), q(50));    // endpoints on edges
		send_segment(q(-100) - 32'd1, q(0), q(100) + 32'd1, q(0));
		send_segment(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
		send_segment(Q_MIN, q(0), Q_MAX, 32'd1);         // steep inverse slope saturates
		send_segment(q(0), Q_MIN, 32'd1, Q_MAX);         // steep slope saturates
		send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_segment(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
		send_segment(q(-120), q(-200), q(120), q(200));  // needs several stages
		send_segment(q(-1000), q(-999), q(1000), q(1001));
		send_segment(32'd0, 32'd0, 32'd0, 32'd0);
		send_segment(q(-150) + 32'd12345, q(-70) + 32'd777, q(130) - 32'd99, q(77) + 32'd3);

		// Random batches, each with its own rectangle. The first three idle
		// the sender lightly and the receiver heavily, the next three the
		// other way round, and the last three do not idle at all.
		for (b = 0; b < RANDOM_BATCHES; b++) begin
			drain();
			case (b / 3)
				0: begin
					send_idle = 6;
					recv_idle = 79;
				end
				1: begin
					send_idle = 79;
					recv_idle = 6;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			case (b)
				0: set_rect(q(-100), q(100), q(-50), q(50));
				1: set_rect(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
				2: set_rect(q(80), q(-80), q(40), q(-40));  // inverted rectangle
				4: set_rect(Q_MIN, 32'd0, 32'd0, Q_MAX);
				5: begin
					// Full range and unsorted, so often inverted.
					w0 = $urandom;
					w1 = $urandom;
					w2 = $urandom;
					w3 = $urandom;
					set_rect(w0, w1, w2, w3);
				end
				6: begin
					// Degenerate: zero width and zero height.
					w0 = $urandom;
					w2 = $urandom;
					set_rect(w0, w0, w2, w2);
				end
				default: begin
					if (b == 7) begin
						w0 = $urandom;
						w1 = $urandom;
						w2 = $urandom;
						w3 = $urandom;
						e0 = longint'($signed(w0));
						e1 = longint'($signed(w1));
						e2 = longint'($signed(w2));
						e3 = longint'($signed(w3));
					end else begin
						e0 = longint'($urandom_range(33554432)) - 16777216;
						e1 = longint'($urandom_range(33554432)) - 16777216;
						e2 = longint'($urandom_range(33554432)) - 16777216;
						e3 = longint'($urandom_range(33554432)) - 16777216;
					end
					w0 = (e0 < e1) ? e0[31:0] : e1[31:0];
					w1 = (e0 < e1) ? e1[31:0] : e0[31:0];
					w2 = (e2 < e3) ? e2[31:0] : e3[31:0];
					w3 = (e2 < e3) ? e3[31:0] : e2[31:0];
					set_rect(w0, w1, w2, w3);
				end
			endcase
			repeat (BATCH_ITEMS) random_segment();
		end

		drain();
		if (fail_count == 0) begin
			$display("line_clip_to_rectangle_unit_tb: PASS");
		end else begin
			$display("line_clip_to_rectangle_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lcr_pkg.sv
rtl/lcr_div.sv
rtl/line_clip_to_rectangle_unit.sv
bench/line_clip_checker.sv
bench/line_clip_to_rectangle_unit_tb.sv
